>>> rtl/core/nec_ir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nec_ir_pkg
// Shared types and constants for the NEC-style pulse-distance transmitter.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

  // Command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_RAW    = 2'd1,
    CMD_PACKED = 2'd2
  } cmd_t;

  localparam int CMD_W      = 2;
  localparam int UNITS_W    = 8;
  localparam int CFG_COUNT  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int WORD_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int S_DATA_W   = 48;
  localparam int M_DATA_W   = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW    = 3'd7;

  typedef logic [UNITS_W-1:0] units_t;
  typedef units_t [CFG_COUNT-1:0] cfg_bank_t;

  // Reset lengths, entry i for register index i
  localparam cfg_bank_t CFG_RESET = '{
    8'd3,   // one low
    8'd1,   // one high
    8'd1,   // zero low
    8'd1,   // zero high
    8'd0,   // end low
    8'd1,   // end high
    8'd8,   // start low
    8'd16   // start high
  };

  // Output tdata bit positions
  localparam int OUT_LINE_BIT = 0;
  localparam int OUT_BUSY_BIT = 1;

endpackage
`default_nettype wire

>>> rtl/core/nec_ir_pulse_transmitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nec_ir_pulse_transmitter
// NEC-style pulse-distance frame generator driven by tick/start transactions.
// ----------------------------------------------------------------------------
// Every input transaction is either a timer tick or a start command and
// yields exactly one output transaction reporting the line level and busy
// flag after it. A start loads the payload (raw 32-bit word, or address and
// command bytes packed with their complements), restarts the frame at once
// and keeps the current line level. Each tick then walks the frame: start
// burst, PAYLOAD_BITS data symbols LSB first, end burst; every symbol is a
// high phase then a low phase whose lengths in ticks come from the eight
// configuration registers (a length of zero lasts one tick). One more tick
// after the end burst drives the line low and clears busy. Throughput is one
// transaction per clock: the phase counter, symbol index and payload shifter
// update in the accepting cycle, and the result lands in a single output
// register, out in the cycle after acceptance; s_tready only drops while that
// register is full and m_tready is low. Configuration writes are taken in
// any cycle and should only be issued while the transmitter is idle.
// ----------------------------------------------------------------------------
module nec_ir_pulse_transmitter #(
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [nec_ir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nec_ir_pkg::UNITS_W-1:0]     cfg_data,
  // Input stream
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // tdata: raw_word[31:0], address_byte[39:32], command_byte[47:40]
  input  wire logic [nec_ir_pkg::S_DATA_W-1:0]    s_tdata,
  // tuser: cmd[1:0]
  input  wire logic [nec_ir_pkg::CMD_W-1:0]       s_tuser,
  // Output stream
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // tdata: line_level[0], busy_res[1], zero fill [7:2]
  output logic [nec_ir_pkg::M_DATA_W-1:0]         m_tdata
);

  localparam int IDX_W = $clog2(PAYLOAD_BITS + 3);
  localparam logic [IDX_W-1:0] LAST_DATA = IDX_W'(PAYLOAD_BITS);
  localparam logic [IDX_W-1:0] END_SYM   = IDX_W'(PAYLOAD_BITS + 1);

  // Configuration bank
  nec_ir_pkg::cfg_bank_t cfg_regs;

  // Frame state
  logic [IDX_W-1:0]                 symbol_index, symbol_index_next;
  logic                             low_phase, low_phase_next;
  nec_ir_pkg::units_t               phase_ticks, phase_ticks_next;
  logic [PAYLOAD_BITS-1:0]          payload, payload_next;
  logic                             sending, sending_next;
  logic                             line_reg, line_reg_next;

  logic                             in_fire;
  logic [nec_ir_pkg::WORD_W-1:0]    raw_word;
  logic [nec_ir_pkg::BYTE_W-1:0]    address_byte;
  logic [nec_ir_pkg::BYTE_W-1:0]    command_byte;
  logic [nec_ir_pkg::WORD_W-1:0]    packed_word;
  logic [PAYLOAD_BITS+nec_ir_pkg::WORD_W-1:0] load_wide;
  logic [PAYLOAD_BITS-1:0]          load_word;
  logic [nec_ir_pkg::CFG_IDX_W-1:0] len_sel;
  nec_ir_pkg::units_t               target;
  nec_ir_pkg::units_t               ticks_inc;
  logic                             in_data;
  logic [nec_ir_pkg::M_DATA_W-1:0]  out_data;

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  // Unpack the payload fields
  assign raw_word     = s_tdata[31:0];
  assign address_byte = s_tdata[39:32];
  assign command_byte = s_tdata[47:40];
  assign packed_word  = {~command_byte, command_byte, ~address_byte, address_byte};

  // Zero-extend or truncate the 32-bit start word to the payload width
  always_comb begin
    if (nec_ir_pkg::cmd_t'(s_tuser) == nec_ir_pkg::CMD_RAW) begin
      load_wide = {{PAYLOAD_BITS{1'b0}}, raw_word};
    end else begin
      load_wide = {{PAYLOAD_BITS{1'b0}}, packed_word};
    end
  end
  assign load_word = load_wide[PAYLOAD_BITS-1:0];

  // Pick the length register for the current phase. The payload shifts right
  // as data symbols complete, so bit 0 is always the bit on the air.
  assign in_data = (symbol_index != '0) && (symbol_index <= LAST_DATA);

  always_comb begin
    if (symbol_index == '0) begin
      len_sel = low_phase ? nec_ir_pkg::CFG_START_LOW : nec_ir_pkg::CFG_START_HIGH;
    end else if (!in_data) begin
      len_sel = low_phase ? nec_ir_pkg::CFG_END_LOW : nec_ir_pkg::CFG_END_HIGH;
    end else if (payload[0]) begin
      len_sel = low_phase ? nec_ir_pkg::CFG_ONE_LOW : nec_ir_pkg::CFG_ONE_HIGH;
    end else begin
      len_sel = low_phase ? nec_ir_pkg::CFG_ZERO_LOW : nec_ir_pkg::CFG_ZERO_HIGH;
    end
  end

  assign target    = cfg_regs[len_sel];
  assign ticks_inc = phase_ticks + 8'd1;

  // Next frame state for the transaction at the input
  always_comb begin
    symbol_index_next = symbol_index;
    low_phase_next    = low_phase;
    phase_ticks_next  = phase_ticks;
    payload_next      = payload;
    sending_next      = sending;
    line_reg_next     = line_reg;
    case (nec_ir_pkg::cmd_t'(s_tuser))
      nec_ir_pkg::CMD_TICK: begin
        if (sending) begin
          if (symbol_index > END_SYM) begin
            // Trailing tick: release the line and go idle
            line_reg_next = 1'b0;
            sending_next  = 1'b0;
          end else begin
            line_reg_next = !low_phase;
            if (ticks_inc < target) begin
              phase_ticks_next = ticks_inc;
            end else begin
              phase_ticks_next = '0;
              if (low_phase) begin
                low_phase_next    = 1'b0;
                symbol_index_next = symbol_index + 1'b1;
                if (in_data) begin
                  payload_next = payload >> 1;
                end
              end else begin
                low_phase_next = 1'b1;
              end
            end
          end
        end
      end
      nec_ir_pkg::CMD_RAW,
      nec_ir_pkg::CMD_PACKED: begin
        // Restart the frame, line holds its level
        payload_next      = load_word;
        symbol_index_next = '0;
        low_phase_next    = 1'b0;
        phase_ticks_next  = '0;
        sending_next      = 1'b1;
      end
      default: begin
        // Reserved command: report state unchanged
      end
    endcase
  end

  // Pack the result word
  always_comb begin
    out_data = '0;
    out_data[nec_ir_pkg::OUT_LINE_BIT] = line_reg_next;
    out_data[nec_ir_pkg::OUT_BUSY_BIT] = sending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs     <= nec_ir_pkg::CFG_RESET;
      symbol_index <= '0;
      low_phase    <= 1'b0;
      phase_ticks  <= '0;
      payload      <= '0;
      sending      <= 1'b0;
      line_reg     <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
    end else begin
      if (cfg_we) begin
        cfg_regs[cfg_index] <= cfg_data;
      end
      if (in_fire) begin
        symbol_index <= symbol_index_next;
        low_phase    <= low_phase_next;
        phase_ticks  <= phase_ticks_next;
        payload      <= payload_next;
        sending      <= sending_next;
        line_reg     <= line_reg_next;
        m_tvalid     <= 1'b1;
        m_tdata      <= out_data;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/nec_ir_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nec_ir_checker
// Port-level checks for the pulse transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module nec_ir_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic [nec_ir_pkg::CMD_W-1:0]     s_tuser,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [nec_ir_pkg::M_DATA_W-1:0]  m_tdata
);

  // Every accepted transaction produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted transaction produced no result");

  // A start always reports busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tuser == nec_ir_pkg::CMD_RAW || s_tuser == nec_ir_pkg::CMD_PACKED)
    |=> m_tdata[nec_ir_pkg::OUT_BUSY_BIT])
    else $error("start did not report busy");

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind nec_ir_pulse_transmitter nec_ir_checker u_nec_ir_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
